### sv/blile_pkg.sv
package blile_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_REMOVE     = 3'd5,
    CMD_FIND       = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        ins;
    logic        rem;
    logic [31:0] value;
  } cell_op_t;

  localparam int unsigned PosW = 7;
  localparam int unsigned ValW = 32;
  localparam logic [PosW-1:0] FOUND_NONE = 7'h7F;
  localparam int unsigned ScanW = 16;

endpackage

### sv/blile_cell.sv
module blile_cell
  import blile_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_op_t        op_i,
  input  logic [CW-1:0]   pos_i,
  input  logic [ValW-1:0] prev_data_i,
  input  logic            prev_valid_i,
  input  logic [ValW-1:0] next_data_i,
  input  logic            next_valid_i,
  output logic [ValW-1:0] data_o,
  output logic            valid_o,
  output logic            match_o,
  output logic            last_o
);

  logic [ValW-1:0] data_q, data_d;
  logic            valid_q, valid_d;
  logic            idx_gt, idx_eq;

  assign idx_gt = CW'(IDX) > pos_i;
  assign idx_eq = CW'(IDX) == pos_i;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (op_i.ins) begin
      valid_d = valid_q | prev_valid_i;
      if (idx_gt) begin
        data_d = prev_data_i;
      end else if (idx_eq) begin
        data_d = op_i.value;
      end
    end else if (op_i.rem) begin
      valid_d = next_valid_i;
      if (idx_gt || idx_eq) begin
        data_d = next_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign match_o = valid_q && (data_q == op_i.value);
  assign last_o  = valid_q && !next_valid_i;

endmodule

### sv/bounded_indexed_list_engine_core.sv
// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells.
// The input channel (in_valid_i/in_ready_o) carries one command per transfer:
// push front or back, pop front or back, insert or remove at a position, or
// find the first entry equal to a value. Every command returns exactly one
// result transfer on the output channel (out_valid_o/out_ready_i) with the
// status, popped value, found index, entry count and the front and back
// entries after the command.
// A command passes the apply step and then the done step, which loads its
// result into the output register. Find adds a scan over the registered
// match flags between the two, 16 cells per cycle, that stops at the first
// hit. Insert and remove shift the cells from the position onward at once
// in the apply step. One command is in flight at a time; the next transfer
// is taken as soon as the result sits in the output register, even while
// the receiver holds off. A stalled receiver stops the block only when a
// second result is ready to be written. Reset empties the list and drops
// any pending result; entry contents are not cleared.
module bounded_indexed_list_engine_core
  import blile_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic [6:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] popped_value_o,
  output logic signed [6:0]  found_index_o,
  output logic [6:0]         entry_count_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;
  localparam int unsigned W    = (DEPTH < ScanW) ? DEPTH : ScanW;
  localparam int unsigned NCH  = (DEPTH + W - 1) / W;
  localparam int unsigned CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned IDXW = $clog2(NCH * W);

  state_e state_q, state_d;

  cmd_e            cmd_q;
  logic [PosW-1:0] pos_q;
  logic [ValW-1:0] val_q;
  logic [CW-1:0]   count_q;
  status_e         status_q;
  logic [ValW-1:0] popped_q;
  logic [PosW-1:0] found_q;
  logic [NCH*W-1:0] match_q;
  logic [CHW-1:0]  chunk_q;

  logic            accept_in;
  logic            apply_en;
  logic            scan_en;
  logic            load_en;
  logic            out_free;

  logic [DEPTH+1:0]   valid_pad;
  logic [ValW-1:0]    data_pad [DEPTH+2];
  logic [DEPTH-1:0]   match_vec;
  logic [DEPTH-1:0]   last_vec;
  logic [ValW-1:0]    back_sel;

  cell_op_t        cell_op;
  logic [CW-1:0]   cell_pos;
  logic            do_ins, do_rem;
  status_e         status_c;
  logic [ValW-1:0] popped_c;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic            full, empty;

  logic [W-1:0]    win;
  logic            win_hit;
  logic [IDXW-1:0] enc;
  logic [IDXW-1:0] base;
  logic            scan_last;

  assign valid_pad[0]       = 1'b1;
  assign valid_pad[DEPTH+1] = 1'b0;
  assign data_pad[0]        = '0;
  assign data_pad[DEPTH+1]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    blile_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (cell_op),
      .pos_i       (cell_pos),
      .prev_data_i (data_pad[i]),
      .prev_valid_i(valid_pad[i]),
      .next_data_i (data_pad[i+2]),
      .next_valid_i(valid_pad[i+2]),
      .data_o      (data_pad[i+1]),
      .valid_o     (valid_pad[i+1]),
      .match_o     (match_vec[i]),
      .last_o      (last_vec[i])
    );
  end

  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_sel = back_sel | ({ValW{last_vec[i]}} & data_pad[i+1]);
    end
  end

  // Command decode against the current occupancy.
  assign pos_ext = CMPW'(pos_q);
  assign cnt_ext = CMPW'(count_q);
  assign full    = count_q >= CW'(DEPTH);
  assign empty   = count_q == '0;

  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    cell_pos = '0;
    status_c = STATUS_OK;
    popped_c = '0;
    case (cmd_q)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          status_c = STATUS_FULL;
        end else begin
          do_ins   = 1'b1;
          cell_pos = (cmd_q == CMD_PUSH_FRONT) ? '0 : count_q;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty) begin
          status_c = STATUS_EMPTY;
        end else begin
          do_rem = 1'b1;
          if (cmd_q == CMD_POP_FRONT) begin
            cell_pos = '0;
            popped_c = data_pad[1];
          end else begin
            cell_pos = count_q - CW'(1);
            popped_c = back_sel;
          end
        end
      end
      CMD_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_c = STATUS_RANGE;
        end else if (full) begin
          status_c = STATUS_FULL;
        end else begin
          do_ins   = 1'b1;
          cell_pos = CW'(pos_ext);
        end
      end
      CMD_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          status_c = STATUS_RANGE;
        end else begin
          do_rem   = 1'b1;
          cell_pos = CW'(pos_ext);
        end
      end
      default: begin
        status_c = STATUS_OK;
      end
    endcase
  end

  assign cell_op.ins   = apply_en & do_ins;
  assign cell_op.rem   = apply_en & do_rem;
  assign cell_op.value = val_q;

  // Find scan over the registered match flags, one window per cycle.
  assign win       = match_q[W-1:0];
  assign win_hit   = |win;
  assign base      = IDXW'(chunk_q) * IDXW'(W);
  assign scan_last = chunk_q == CHW'(NCH - 1);

  always_comb begin
    enc = '0;
    for (int k = W - 1; k >= 0; k--) begin
      if (win[k]) begin
        enc = IDXW'(k);
      end
    end
  end

  assign out_free = !out_valid_o || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_d = (cmd_q == CMD_FIND) ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (win_hit || scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    apply_en   = 1'b0;
    scan_en    = 1'b0;
    load_en    = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_APPLY: apply_en   = 1'b1;
      ST_SCAN:  scan_en    = 1'b1;
      ST_DONE:  load_en    = out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign accept_in = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply_en) begin
        if (do_ins) begin
          count_q <= count_q + CW'(1);
        end else if (do_rem) begin
          count_q <= count_q - CW'(1);
        end
      end
      if (load_en) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cmd_q <= cmd_e'(cmd_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (apply_en) begin
      status_q <= status_c;
      popped_q <= popped_c;
      found_q  <= FOUND_NONE;
      match_q  <= (NCH * W)'(match_vec);
      chunk_q  <= '0;
    end
    if (scan_en) begin
      if (win_hit) begin
        found_q <= PosW'(base + enc);
      end else begin
        match_q <= match_q >> W;
        chunk_q <= chunk_q + CHW'(1);
      end
    end
    if (load_en) begin
      status_o       <= status_q;
      popped_value_o <= popped_q;
      found_index_o  <= found_q;
      entry_count_o  <= PosW'(count_q);
      front_value_o  <= valid_pad[1] ? data_pad[1] : '0;
      back_value_o   <= back_sel;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy exceeds the list depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_pad[DEPTH:1]) == int'(count_q))
    else $error("cell valid flags disagree with the occupancy count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> cmd_q == CMD_FIND)
    else $error("match scan running for a command other than find");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> state_q == ST_APPLY)
    else $error("accepted command did not reach the apply step");

endmodule
